FILE: rtl/core/sha256_message_hasher_top_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 message hasher - assertion macros
// Shared helpers for the concurrent checks in the hasher modules.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_TOP_MACROS_SVH
`define SHA256_MESSAGE_HASHER_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SHAMH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("shamh: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define SHAMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("shamh: next-cycle check failed");

`endif

FILE: rtl/core/shamh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher - package
// Constants, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package shamh_pkg;

	localparam int unsigned FILL_W = 6;

	// fill count at which the last byte of a block goes in
	localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
	// fill count at which the length field starts
	localparam logic [FILL_W-1:0] FILL_LEN  = 6'd56;

	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

	localparam logic [31:0] HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_COMP_INIT,
		ST_COMP_ROUND,
		ST_COMP_FINAL,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic shift_msg;
		logic shift_mark;
		logic shift_zero;
		logic shift_len;
		logic comp_init;
		logic comp_round;
		logic comp_final;
		logic new_msg;
	} dp_cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic              round_last;
	} dp_sts_t;

endpackage

FILE: rtl/core/sha256_message_hasher_top.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher - top level
// Hashes a byte stream and returns the eight-word digest per message.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                         | tuser         | tlast
//  --------+-----+-------------------------------+---------------+-----------
//  s_*     | in  | [7:0] msg_byte                | byte_present  | last_item
//  m_*     | out | [31:0] digest_word,[34:32] idx| -             | last_word
//
//  Timing: message bytes are taken one per cycle while the controller is idle;
//  every 64th block byte starts a compression (load, 64 rounds on one shared
//  round unit, fold). The final word adds padding bytes up to the block end,
//  a turn state before the length field (and an extra compression when 56 or
//  more bytes are pending), the closing compression and a hand-off state.
//  Eight digest words then drain at one per cycle while the receiver is ready,
//  from the output unit while the next message is already taken in.
//  Reset clears control state and reloads the initial hash; no clearing pass.
//  A stalled digest holds; a new message waits at its end until it drains.
// ----------------------------------------------------------------------------
module sha256_message_hasher_top
	import shamh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] msg_byte
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_tlast
);

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [7:0][31:0] hash;
	logic             out_busy;
	logic             out_load;
	logic [31:0]      digest_word;
	logic [2:0]       word_index;

	// sequence intake, padding and compression
	shamh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_present (s_tuser),
		.in_last    (s_tlast),
		.in_ready   (s_tready),
		.sts        (sts),
		.cmd        (cmd),
		.out_busy   (out_busy),
		.out_load   (out_load)
	);

	// block window, round unit and chaining hash
	shamh_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.msg_byte (s_tdata),
		.sts      (sts),
		.hash     (hash)
	);

	// hold the finished digest and drain it word by word
	shamh_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (out_load),
		.digest      (hash),
		.busy        (out_busy),
		.valid       (m_tvalid),
		.ready       (m_tready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (m_tlast)
	);

	assign m_tdata = {5'b00000, word_index, digest_word};

endmodule

FILE: rtl/core/shamh_dp.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher - datapath
// Block/schedule shift line, round unit, chaining hash and length counter.
// ----------------------------------------------------------------------------
module shamh_dp
	import shamh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  logic [7:0]       msg_byte,
	output dp_sts_t          sts,
	output logic [7:0][31:0] hash
);

	logic [31:0]       sched_q [16];
	logic [7:0][31:0]  hash_q;
	logic [31:0]       a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [FILL_W-1:0] fill_q;
	logic [63:0]       bits_q;
	logic [5:0]        round_q;

	logic        shift_any;
	logic [7:0]  byte_in;
	logic [7:0]  len_byte;
	logic [31:0] w_next;
	logic [31:0] big_s1, ch, t1, big_s0, maj, t2;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return 32'({x, x} >> n);
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	assign shift_any = cmd.shift_msg | cmd.shift_mark | cmd.shift_zero | cmd.shift_len;

	// length field goes out most significant byte first
	assign len_byte = 8'(bits_q >> {~fill_q[2:0], 3'b000});

	always_comb begin
		if (cmd.shift_msg) begin
			byte_in = msg_byte;
		end else if (cmd.shift_mark) begin
			byte_in = PAD_MARK_BYTE;
		end else if (cmd.shift_len) begin
			byte_in = len_byte;
		end else begin
			byte_in = 8'h00;
		end
	end

	assign w_next = small_sig1(sched_q[14]) + sched_q[9] + small_sig0(sched_q[1]) + sched_q[0];

	assign big_s1 = rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25);
	assign ch     = (e_q & f_q) ^ (~e_q & g_q);
	assign t1     = h_q + big_s1 + ch + ROUND_K[round_q] + sched_q[0];
	assign big_s0 = rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22);
	assign maj    = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
	assign t2     = big_s0 + maj;

	// block bytes enter at the low byte of the last word; during rounds the window advances a word
	always_ff @(posedge clk) begin
		if (shift_any) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= {sched_q[i][23:0], sched_q[i+1][31:24]};
			end
			sched_q[15] <= {sched_q[15][23:0], byte_in};
		end else if (cmd.comp_round) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[15] <= w_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.comp_init) begin
			a_q <= hash_q[0];
			b_q <= hash_q[1];
			c_q <= hash_q[2];
			d_q <= hash_q[3];
			e_q <= hash_q[4];
			f_q <= hash_q[5];
			g_q <= hash_q[6];
			h_q <= hash_q[7];
		end else if (cmd.comp_round) begin
			h_q <= g_q;
			g_q <= f_q;
			f_q <= e_q;
			e_q <= d_q + t1;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= a_q;
			a_q <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= HASH_IV[i];
			end
		end else if (cmd.new_msg) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= HASH_IV[i];
			end
		end else if (cmd.comp_final) begin
			hash_q[0] <= hash_q[0] + a_q;
			hash_q[1] <= hash_q[1] + b_q;
			hash_q[2] <= hash_q[2] + c_q;
			hash_q[3] <= hash_q[3] + d_q;
			hash_q[4] <= hash_q[4] + e_q;
			hash_q[5] <= hash_q[5] + f_q;
			hash_q[6] <= hash_q[6] + g_q;
			hash_q[7] <= hash_q[7] + h_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			bits_q  <= '0;
			round_q <= '0;
		end else begin
			if (cmd.new_msg) begin
				fill_q <= '0;
			end else if (shift_any) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.new_msg) begin
				bits_q <= '0;
			end else if (cmd.shift_msg) begin
				bits_q <= bits_q + 64'd8;
			end
			if (cmd.comp_init) begin
				round_q <= '0;
			end else if (cmd.comp_round) begin
				round_q <= round_q + 1'b1;
			end
		end
	end

	assign sts.fill       = fill_q;
	assign sts.round_last = &round_q;
	assign hash           = hash_q;

endmodule

FILE: rtl/core/shamh_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher - controller
// Sequences byte intake, padding, compression and digest hand-off.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_top_macros.svh"

module shamh_ctrl
	import shamh_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_present,
	input  logic    in_last,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	input  logic    out_busy,
	output logic    out_load
);

	ctrl_state_t state_q, state_d;
	ctrl_state_t ret_q, ret_d;
	logic        any_shift;
	logic        block_full;

	assign block_full = (sts.fill == FILL_LAST);
	assign any_shift  = cmd.shift_msg | cmd.shift_mark | cmd.shift_zero | cmd.shift_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_present) begin
						cmd.shift_msg = 1'b1;
						if (block_full) begin
							state_d = ST_COMP_INIT;
							ret_d   = in_last ? ST_PAD_MARK : ST_IDLE;
						end else if (in_last) begin
							state_d = ST_PAD_MARK;
						end
					end else if (in_last) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_PAD_MARK: begin
				cmd.shift_mark = 1'b1;
				if (block_full) begin
					state_d = ST_COMP_INIT;
					ret_d   = ST_PAD_ZERO;
				end else begin
					state_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				if (sts.fill == FILL_LEN) begin
					state_d = ST_PAD_LEN;
				end else begin
					cmd.shift_zero = 1'b1;
					if (block_full) begin
						state_d = ST_COMP_INIT;
						ret_d   = ST_PAD_ZERO;
					end
				end
			end
			ST_PAD_LEN: begin
				cmd.shift_len = 1'b1;
				if (block_full) begin
					state_d = ST_COMP_INIT;
					ret_d   = ST_EMIT;
				end
			end
			ST_COMP_INIT: begin
				cmd.comp_init = 1'b1;
				state_d       = ST_COMP_ROUND;
			end
			ST_COMP_ROUND: begin
				cmd.comp_round = 1'b1;
				if (sts.round_last) begin
					state_d = ST_COMP_FINAL;
				end
			end
			ST_COMP_FINAL: begin
				cmd.comp_final = 1'b1;
				state_d        = ret_q;
			end
			ST_EMIT: begin
				if (!out_busy) begin
					out_load    = 1'b1;
					cmd.new_msg = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`SHAMH_ASSERT_NEXT(a_round_end, clk, arst_n, state_q == ST_COMP_ROUND && sts.round_last, state_q == ST_COMP_FINAL)
	`SHAMH_ASSERT_IMPL(a_load_free, clk, arst_n, out_load, !out_busy && state_q == ST_EMIT)
	`SHAMH_ASSERT_NEXT(a_full_block, clk, arst_n, any_shift && block_full, state_q == ST_COMP_INIT)

endmodule

FILE: rtl/core/shamh_out.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher - digest output
// Holds a finished digest and drains it one word per handshake.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_top_macros.svh"

module shamh_out
	import shamh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [7:0][31:0] digest,
	output logic             busy,
	output logic             valid,
	input  logic             ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	logic [31:0] word_q [8];
	logic [2:0]  cnt_q;
	logic        valid_q;
	logic        take;

	assign take = valid_q & ready;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < 8; i++) begin
				word_q[i] <= digest[i];
			end
		end else if (take) begin
			for (int i = 0; i < 7; i++) begin
				word_q[i] <= word_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= '0;
		end else if (take) begin
			cnt_q <= cnt_q + 1'b1;
			if (&cnt_q) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign busy        = valid_q;
	assign valid       = valid_q;
	assign digest_word = word_q[0];
	assign word_index  = cnt_q;
	assign last_word   = &cnt_q;

	`SHAMH_ASSERT_NEXT(a_load_first, clk, arst_n, load, valid_q && cnt_q == 3'd0)
	`SHAMH_ASSERT_NEXT(a_drain_end, clk, arst_n, take && (&cnt_q), !valid_q)
	`SHAMH_ASSERT_NEXT(a_drain_mid, clk, arst_n, take && !(&cnt_q), valid_q)

endmodule

FILE: dv/tb_sha256_message_hasher_top.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher - testbench
// Streams byte messages into the hasher and checks every digest word against
// an in-bench SHA-256 computation, under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_sha256_message_hasher_top;
	timeunit 1ns;
	timeprecision 1ps;

	import shamh_pkg::*;

	localparam int NUM_PHASES   = 4;
	localparam int PHASE_WORDS  = 70;
	localparam int LONG_HOLD    = 600;
	localparam int DRAIN_CYCLES = 300;
	localparam int MSG_BYTES_MAX = 140;

	// sender gap and receiver stall odds (percent), one pair per phase
	localparam int PHASE_GAP   [NUM_PHASES] = '{0, 45, 0, 10};
	localparam int PHASE_STALL [NUM_PHASES] = '{0, 0, 45, 10};

	// message lengths around the padding and block boundaries
	localparam int BOUNDARY_LEN [8] = '{55, 56, 57, 63, 64, 65, 119, 128};

	typedef struct {
		logic [7:0] data;
		logic       present;
		logic       last;
	} byte_word_t;

	typedef struct {
		logic [31:0] digest;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	sha256_message_hasher_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Run control shared by the stimulus, driver and receiver
	// ------------------------------------------------------------------------
	byte_word_t   pending_words [$];
	digest_word_t digest_due [$];

	int gap_pct       = 0;
	int stall_pct     = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	logic word_taken  = 1'b0;

	int fail_count     = 0;
	int words_in       = 0;
	int messages_in    = 0;
	int digest_checked = 0;

	// ------------------------------------------------------------------------
	// Hash state of the predictor: one message in flight
	// ------------------------------------------------------------------------
	logic [7:0]  chunk [64];
	int          chunk_fill;
	logic [63:0] msg_bits;
	logic [31:0] hash_acc [8];

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic start_message();
		for (int k = 0; k < 8; k++)
			hash_acc[k] = HASH_IV[k];
		chunk_fill = 0;
		msg_bits = '0;
	endtask

	// One full 64-round compression of the current chunk into hash_acc.
	task automatic compress_chunk();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int r = 0; r < 16; r++)
			w[r] = {chunk[4*r], chunk[4*r+1], chunk[4*r+2], chunk[4*r+3]};
		for (int r = 16; r < 64; r++) begin
			s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
			s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
			w[r] = w[r-16] + s0 + w[r-7] + s1;
		end
		a = hash_acc[0]; b = hash_acc[1]; c = hash_acc[2]; d = hash_acc[3];
		e = hash_acc[4]; f = hash_acc[5]; g = hash_acc[6]; h = hash_acc[7];
		for (int r = 0; r < 64; r++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[r] + w[r];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_acc[0] += a; hash_acc[1] += b; hash_acc[2] += c; hash_acc[3] += d;
		hash_acc[4] += e; hash_acc[5] += f; hash_acc[6] += g; hash_acc[7] += h;
	endtask

	// Take one accepted word; on the final word pad, close and queue the digest.
	task automatic absorb_word(input logic [7:0] data, input logic present, input logic last);
		int i;
		digest_word_t dw;
		if (present) begin
			chunk[chunk_fill] = data;
			chunk_fill++;
			msg_bits += 64'd8;
			if (chunk_fill == 64) begin
				compress_chunk();
				chunk_fill = 0;
			end
		end
		if (!last)
			return;
		i = chunk_fill;
		chunk[i] = PAD_MARK_BYTE;
		i++;
		// no room left for the length field: spill into an extra block
		if (i > 56) begin
			while (i < 64) begin
				chunk[i] = 8'h00;
				i++;
			end
			compress_chunk();
			i = 0;
		end
		while (i < 56) begin
			chunk[i] = 8'h00;
			i++;
		end
		for (int k = 0; k < 8; k++)
			chunk[56 + k] = msg_bits[63 - 8*k -: 8];
		compress_chunk();
		for (int k = 0; k < 8; k++) begin
			dw.digest = hash_acc[k];
			dw.index  = 3'(k);
			dw.last   = (k == 7);
			digest_due.push_back(dw);
		end
		messages_in++;
		start_message();
	endtask

	task automatic check_digest_word(input logic [39:0] data, input logic last);
		digest_word_t want;
		if (digest_due.size() == 0) begin
			$error("digest word %h with none expected", data[31:0]);
			fail_count++;
			return;
		end
		want = digest_due.pop_front();
		if (data[31:0] !== want.digest) begin
			$error("digest_word: expected %h, got %h", want.digest, data[31:0]);
			fail_count++;
		end
		if (data[34:32] !== want.index) begin
			$error("word_index: expected %0d, got %0d", want.index, data[34:32]);
			fail_count++;
		end
		if (last !== want.last) begin
			$error("last_word: expected %0b, got %0b", want.last, last);
			fail_count++;
		end
		digest_checked++;
	endtask

	// ------------------------------------------------------------------------
	// Monitor: sample both handshakes at the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		word_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			words_in++;
			absorb_word(s_tdata, s_tuser, s_tlast);
		end
		if (arst_n && m_tvalid && m_tready)
			check_digest_word(m_tdata, m_tlast);
	end

	// ------------------------------------------------------------------------
	// Driver: advance on the falling edge; hold a word until it is taken
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		byte_word_t bw;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || word_taken) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
				bw = pending_words.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= bw.data;
				s_tuser  <= bw.present;
				s_tlast  <= bw.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Long receiver hold: count it down here, independent of the stimulus.
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left   <= LONG_HOLD;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: stall at random per phase, and fully during a long hold.
	always @(negedge clk)
		m_tready <= arst_n && (hold_left == 0) && ($urandom_range(99) >= stall_pct);

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	function automatic int pick_length();
		int sel;
		sel = $urandom_range(99);
		if (sel < 65)
			return $urandom_range(40);
		else if (sel < 90)
			return BOUNDARY_LEN[$urandom_range(7)];
		else
			return $urandom_range(MSG_BYTES_MAX, 66);
	endfunction

	task automatic push_word(input logic [7:0] data, input logic present, input logic last);
		byte_word_t bw;
		bw.data    = data;
		bw.present = present;
		bw.last    = last;
		pending_words.push_back(bw);
	endtask

	// Queue one message of len bytes with random content and scattered empty
	// words; the final word either carries the last byte or is an empty marker.
	task automatic queue_message(input int len, output int counted);
		int tail_byte;
		tail_byte = (len != 0) ? $urandom_range(1) : 0;
		counted = 0;
		for (int k = 0; k < len - tail_byte; k++) begin
			if ($urandom_range(99) < 8)
				push_word(8'($urandom), 1'b0, 1'b0);
			push_word(8'($urandom), 1'b1, 1'b0);
			counted++;
		end
		push_word(8'($urandom), tail_byte != 0, 1'b1);
		counted++;
	endtask

	task automatic wait_queue_empty();
		while (pending_words.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	initial begin
		int n;
		int budget;

		start_message();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty message, single bytes at the extremes, a byte with
		// the final flag, ignored empty words, and the classic "abc" message.
		// The 2^64 bit-count wrap is out of reach in simulation.
		push_word(8'hA5, 1'b0, 1'b1);
		push_word(8'hFF, 1'b1, 1'b1);
		push_word(8'h00, 1'b1, 1'b0);
		push_word(8'h3C, 1'b0, 1'b0);
		push_word(8'hC3, 1'b0, 1'b0);
		push_word(8'h5A, 1'b0, 1'b1);
		push_word(8'h61, 1'b1, 1'b0);
		push_word(8'h62, 1'b1, 1'b0);
		push_word(8'h63, 1'b1, 1'b1);
		push_word(8'h80, 1'b1, 1'b0);
		push_word(8'h7F, 1'b0, 1'b0);
		push_word(8'h7F, 1'b1, 1'b0);
		push_word(8'h01, 1'b1, 1'b0);
		push_word(8'hFE, 1'b1, 1'b0);
		push_word(8'h55, 1'b1, 1'b1);
		wait_queue_empty();

		// Pressure: hold the digest side off while more messages arrive, so the
		// first digest backs up and the next message stalls at its end.
		hold_requests++;
		queue_message(9, n);
		queue_message(20, n);
		queue_message(4, n);
		wait_queue_empty();

		for (int p = 0; p < NUM_PHASES; p++) begin
			gap_pct   = PHASE_GAP[p];
			stall_pct = PHASE_STALL[p];
			budget = 0;
			while (budget < PHASE_WORDS) begin
				queue_message(pick_length(), n);
				budget += n;
			end
			wait_queue_empty();
		end

		while (digest_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d input words over %0d messages, %0d digest words checked",
			words_in, messages_in, digest_checked);
		$display("phases: no idling, sender gaps, receiver stalls, both, plus one long hold");
		if (fail_count == 0)
			$display("sha256_message_hasher_top: match");
		else
			$display("sha256_message_hasher_top: mismatch");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#10000000;
		$display("sha256_message_hasher_top: mismatch");
		$finish;
	end

endmodule
